FILE: sv/live_min_max_tree_unit_defines.svh
// Assertion helpers for the live min/max tree unit.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef LIVE_MIN_MAX_TREE_UNIT_DEFINES_SVH
`define LIVE_MIN_MAX_TREE_UNIT_DEFINES_SVH

// Same-cycle implication
`define LMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lmm_pkg.sv
`timescale 1ns / 1ps

package lmm_pkg;

    // Fixed port field widths
    localparam int ACT_W = 1;
    localparam int POS_W = 10;
    localparam int VAL_W = 31;

    // Defaults for the top-level parameters
    localparam int DEF_SLOTS      = 1024;
    localparam int DEF_VALUE_BITS = 31;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_LOAD   = 1'b0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 1'b1;

endpackage

FILE: sv/live_min_max_tree_unit.sv
`timescale 1ns / 1ps
// Live min/max tree unit.
// Input channel (i_in_valid / o_in_ready): one transfer carries an action,
// a slot position and a value. Load writes the value into the slot and makes
// it live, remove takes the slot out; a load of zero changes nothing and is
// flagged in o_bad_value. Positions at or above SLOTS change nothing.
// Output channel (o_out_valid / i_out_ready): one result per input transfer,
// giving the global min and max live values with their slots, and
// o_all_empty when nothing is live.
// Update path: an update walks from the leaf to the root, each tree level
// taking a read state (sibling read from node memory) and then a merge state
// (merge and parent write); the root result then goes to the output register.
// An item that changes nothing reads the root only and skips the walk.
// One item is in flight at a time; a new transfer is taken as soon as the
// previous result sits in the output register.
// Reset: a clearing pass writes every node memory entry to empty, with
// o_in_ready low until it ends.
// A stalled receiver holds the result; the next result waits until it is taken.

`include "live_min_max_tree_unit_defines.svh"

module live_min_max_tree_unit #(
    parameter int SLOTS      = lmm_pkg::DEF_SLOTS,
    parameter int VALUE_BITS = lmm_pkg::DEF_VALUE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [lmm_pkg::ACT_W-1:0] i_action,
    input  logic [lmm_pkg::POS_W-1:0] i_position,
    input  logic [lmm_pkg::VAL_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [lmm_pkg::VAL_W-1:0] o_min_value,
    output logic [lmm_pkg::POS_W-1:0] o_min_slot,
    output logic [lmm_pkg::VAL_W-1:0] o_max_value,
    output logic [lmm_pkg::POS_W-1:0] o_max_slot,
    output logic                      o_all_empty,
    output logic                      o_bad_value
);

    import lmm_pkg::*;

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int NODE_BITS = $clog2(2 * SLOTS);
    localparam int DEPTH     = 2 * SLOTS;
    localparam int NODE_W    = 1 + 2 * (VALUE_BITS + SLOT_BITS);

    localparam logic [NODE_BITS-1:0] ROOT      = NODE_BITS'(1);
    localparam logic [NODE_BITS-1:0] LAST      = NODE_BITS'(DEPTH - 1);
    localparam logic [NODE_BITS-1:0] LEAF_BASE = NODE_BITS'(SLOTS);

    typedef struct packed {
        logic                  live;
        logic [VALUE_BITS-1:0] min_val;
        logic [SLOT_BITS-1:0]  min_slot;
        logic [VALUE_BITS-1:0] max_val;
        logic [SLOT_BITS-1:0]  max_slot;
    } t_node;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MERGE,
        S_ROOT,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [NODE_BITS-1:0] r_clr_addr;
    logic [NODE_BITS-1:0] r_idx;
    t_node                r_cur;
    logic                 r_bad;
    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_min_value;
    logic [POS_W-1:0]     r_min_slot;
    logic [VAL_W-1:0]     r_max_value;
    logic [POS_W-1:0]     r_max_slot;
    logic                 r_all_empty;
    logic                 r_bad_value;

    logic                  in_xfer;
    logic [VALUE_BITS-1:0] load_val;
    logic                  is_load;
    logic                  zero_load;
    logic                  in_range;
    logic                  do_change;
    logic [NODE_BITS-1:0]  leaf_idx;
    t_node                 leaf_node;
    logic [NODE_BITS-1:0]  sib_idx;
    logic [NODE_BITS-1:0]  par_idx;
    t_node                 rd_node;
    t_node                 merged;
    logic [NODE_W-1:0]     rd_data;
    logic [NODE_W-1:0]     merge_left;
    logic [NODE_W-1:0]     merge_right;
    logic [NODE_W-1:0]     merge_out;
    logic                  mem_we;
    logic [NODE_BITS-1:0]  mem_waddr;
    logic [NODE_W-1:0]     mem_wdata;
    logic [NODE_BITS-1:0]  mem_raddr;
    logic                  out_free;

    // input decode
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign load_val   = i_value[VALUE_BITS-1:0];
    assign is_load    = (i_action == ACT_LOAD);
    assign zero_load  = is_load && (load_val == '0);
    assign in_range   = 32'(i_position) < 32'(SLOTS);
    assign do_change  = !zero_load && in_range;
    assign leaf_idx   = LEAF_BASE + NODE_BITS'(i_position);

    // new leaf contents: live copy of the value on load, empty on remove
    always_comb begin
        leaf_node = '0;
        if (is_load) begin
            leaf_node.live     = 1'b1;
            leaf_node.min_val  = load_val;
            leaf_node.min_slot = SLOT_BITS'(i_position);
            leaf_node.max_val  = load_val;
            leaf_node.max_slot = SLOT_BITS'(i_position);
        end
    end

    // tree walk addressing
    assign sib_idx = {r_idx[NODE_BITS-1:1], ~r_idx[0]};
    assign par_idx = {1'b0, r_idx[NODE_BITS-1:1]};
    assign rd_node = t_node'(rd_data);

    // even index is the left child
    assign merge_left  = r_idx[0] ? rd_data : NODE_W'(r_cur);
    assign merge_right = r_idx[0] ? NODE_W'(r_cur) : rd_data;
    assign merged      = t_node'(merge_out);

    lmm_merge #(
        .VALUE_BITS (VALUE_BITS),
        .SLOT_BITS  (SLOT_BITS),
        .NODE_W     (NODE_W)
    ) u_merge (
        .i_left   (merge_left),
        .i_right  (merge_right),
        .o_parent (merge_out)
    );

    // node memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        mem_raddr = ROOT;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                mem_we    = in_xfer && do_change;
                mem_waddr = leaf_idx;
                mem_wdata = NODE_W'(leaf_node);
            end
            S_READ: begin
                mem_raddr = sib_idx;
            end
            S_MERGE: begin
                mem_we    = 1'b1;
                mem_waddr = par_idx;
                mem_wdata = merge_out;
            end
            default: begin
            end
        endcase
    end

    lmm_node_ram #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (NODE_BITS),
        .WIDTH     (NODE_W)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    assign out_free = !r_out_valid || i_out_ready;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE sets valid itself when the register frees up
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + NODE_BITS'(1);
                    if (r_clr_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_bad   <= zero_load;
                        r_cur   <= leaf_node;
                        r_idx   <= leaf_idx;
                        r_state <= do_change ? S_READ : S_ROOT;
                    end
                end
                S_READ: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    r_cur   <= merged;
                    r_idx   <= par_idx;
                    r_state <= (par_idx == ROOT) ? S_DONE : S_READ;
                end
                S_ROOT: begin
                    r_cur   <= rd_node;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_min_value <= VAL_W'(r_cur.min_val);
                        r_min_slot  <= POS_W'(r_cur.min_slot);
                        r_max_value <= VAL_W'(r_cur.max_val);
                        r_max_slot  <= POS_W'(r_cur.max_slot);
                        r_all_empty <= !r_cur.live;
                        r_bad_value <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_min_value = r_min_value;
    assign o_min_slot  = r_min_slot;
    assign o_max_value = r_max_value;
    assign o_max_slot  = r_max_slot;
    assign o_all_empty = r_all_empty;
    assign o_bad_value = r_bad_value;

    // checks
    `LMM_ASSERT_NOW(a_dead_root_zero, (r_state == S_DONE) && !r_cur.live, (r_cur.min_val == '0) && (r_cur.max_val == '0), "empty root carries data")
    `LMM_ASSERT_NOW(a_min_le_max, (r_state == S_DONE) && r_cur.live, r_cur.min_val <= r_cur.max_val, "root min above root max")
    `LMM_ASSERT_NOW(a_walk_below_root, (r_state == S_READ) || (r_state == S_MERGE), r_idx > ROOT, "tree walk passed the root")
    `LMM_ASSERT_NEXT(a_result_after_done, (r_state == S_DONE) && out_free, r_out_valid && (r_state == S_IDLE), "finished result not presented")

endmodule

FILE: sv/lmm_node_ram.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read node memory, registered read data
module lmm_node_ram #(
    parameter int DEPTH     = 2048,
    parameter int ADDR_BITS = 11,
    parameter int WIDTH     = 83
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lmm_merge.sv
`timescale 1ns / 1ps

// Combines two child nodes into their parent node.
// Ties on value go to the smaller slot, for both min and max.
module lmm_merge #(
    parameter int VALUE_BITS = 31,
    parameter int SLOT_BITS  = 10,
    parameter int NODE_W     = 1 + 2 * (VALUE_BITS + SLOT_BITS)
) (
    input  logic [NODE_W-1:0] i_left,
    input  logic [NODE_W-1:0] i_right,
    output logic [NODE_W-1:0] o_parent
);

    typedef struct packed {
        logic                  live;
        logic [VALUE_BITS-1:0] min_val;
        logic [SLOT_BITS-1:0]  min_slot;
        logic [VALUE_BITS-1:0] max_val;
        logic [SLOT_BITS-1:0]  max_slot;
    } t_node;

    t_node l_node;
    t_node r_node;
    t_node p_node;
    logic  left_min_wins;
    logic  left_max_wins;

    assign l_node = t_node'(i_left);
    assign r_node = t_node'(i_right);

    // winner selection when both children are live
    assign left_min_wins = (l_node.min_val < r_node.min_val) ||
                           ((l_node.min_val == r_node.min_val) &&
                            (l_node.min_slot <= r_node.min_slot));
    assign left_max_wins = (l_node.max_val > r_node.max_val) ||
                           ((l_node.max_val == r_node.max_val) &&
                            (l_node.max_slot <= r_node.max_slot));

    always_comb begin
        p_node = '0;
        if (l_node.live && r_node.live) begin
            p_node.live = 1'b1;
            if (left_min_wins) begin
                p_node.min_val  = l_node.min_val;
                p_node.min_slot = l_node.min_slot;
            end else begin
                p_node.min_val  = r_node.min_val;
                p_node.min_slot = r_node.min_slot;
            end
            if (left_max_wins) begin
                p_node.max_val  = l_node.max_val;
                p_node.max_slot = l_node.max_slot;
            end else begin
                p_node.max_val  = r_node.max_val;
                p_node.max_slot = r_node.max_slot;
            end
        end else if (l_node.live) begin
            p_node = l_node;
        end else if (r_node.live) begin
            p_node = r_node;
        end
    end

    assign o_parent = NODE_W'(p_node);

endmodule

FILE: sim/live_min_max_tree_unit_tb.sv
`timescale 1ns / 1ps

module live_min_max_tree_unit_tb;

    import lmm_pkg::*;

    localparam int SLOTS       = DEF_SLOTS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 40;

    // One result of the block: global extremes plus flags
    typedef struct packed {
        logic [VAL_W-1:0] min_value;
        logic [POS_W-1:0] min_slot;
        logic [VAL_W-1:0] max_value;
        logic [POS_W-1:0] max_slot;
        logic             all_empty;
        logic             bad_value;
    } t_extremes;

    // Tracks live slots and queues the extremes each update should produce
    class tree_scoreboard;
        bit               slot_live  [SLOTS];
        logic [VAL_W-1:0] slot_value [SLOTS];
        t_extremes        pending_extremes [$];
        int unsigned      error_count;

        function new();
            foreach (slot_live[s]) begin
                slot_live[s]  = 1'b0;
                slot_value[s] = '0;
            end
            error_count = 0;
        endfunction

        // Apply one accepted update and queue the resulting extremes
        function void note_update(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                  logic [VAL_W-1:0] val);
            t_extremes exp_res;
            bit        found;
            exp_res = '0;
            found   = 1'b0;
            if (act == ACT_LOAD && val == '0) begin
                exp_res.bad_value = 1'b1;
            end else if (int'(pos) < SLOTS) begin
                slot_live[pos]  = (act == ACT_LOAD);
                slot_value[pos] = (act == ACT_LOAD) ? val : '0;
            end
            // Ascending scan with strict compares: lowest slot wins on ties
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_live[s]) begin
                    if (!found || slot_value[s] < exp_res.min_value) begin
                        exp_res.min_value = slot_value[s];
                        exp_res.min_slot  = POS_W'(s);
                    end
                    if (!found || slot_value[s] > exp_res.max_value) begin
                        exp_res.max_value = slot_value[s];
                        exp_res.max_slot  = POS_W'(s);
                    end
                    found = 1'b1;
                end
            end
            exp_res.all_empty = !found;
            pending_extremes.push_back(exp_res);
        endfunction

        // Compare one result against the oldest expectation
        function void check_extremes(t_extremes got);
            t_extremes want;
            if (pending_extremes.size() == 0) begin
                $error("result transfer with no expectation pending");
                error_count++;
                return;
            end
            want = pending_extremes.pop_front();
            if (got.min_value !== want.min_value) begin
                $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
                error_count++;
            end
            if (got.min_slot !== want.min_slot) begin
                $error("min_slot: expected %0d, got %0d", want.min_slot, got.min_slot);
                error_count++;
            end
            if (got.max_value !== want.max_value) begin
                $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
                error_count++;
            end
            if (got.max_slot !== want.max_slot) begin
                $error("max_slot: expected %0d, got %0d", want.max_slot, got.max_slot);
                error_count++;
            end
            if (got.all_empty !== want.all_empty) begin
                $error("all_empty: expected %0d, got %0d", want.all_empty, got.all_empty);
                error_count++;
            end
            if (got.bad_value !== want.bad_value) begin
                $error("bad_value: expected %0d, got %0d", want.bad_value, got.bad_value);
                error_count++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [ACT_W-1:0]   i_action;
    logic [POS_W-1:0]   i_position;
    logic [VAL_W-1:0]   i_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [VAL_W-1:0]   o_min_value;
    logic [POS_W-1:0]   o_min_slot;
    logic [VAL_W-1:0]   o_max_value;
    logic [POS_W-1:0]   o_max_slot;
    logic               o_all_empty;
    logic               o_bad_value;

    tree_scoreboard     sb;
    int unsigned        cycle_count = 0;
    int unsigned        items_sent  = 0;
    int unsigned        burst_left  = 0;

    live_min_max_tree_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_min_value (o_min_value),
        .o_min_slot  (o_min_slot),
        .o_max_value (o_max_value),
        .o_max_slot  (o_max_slot),
        .o_all_empty (o_all_empty),
        .o_bad_value (o_bad_value)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_extremes got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.min_value = o_min_value;
            got.min_slot  = o_min_slot;
            got.max_value = o_max_value;
            got.max_slot  = o_max_slot;
            got.all_empty = o_all_empty;
            got.bad_value = o_bad_value;
            sb.check_extremes(got);
        end
    end

    // Receiver: shifting stall modes, plus one long hold-off to back up the input
    initial begin
        int  mode_left;
        int  mode;
        bit  hold_done;
        mode_left = 0;
        mode      = 0;
        hold_done = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_sent >= 400) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_out_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // One update transfer; inserts a random gap between bursts
    task automatic send_update(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_update(act, pos, val);
        items_sent++;
    endtask

    // Random updates in phases: wide or narrow slot window, wide or tiny values
    task automatic run_random_updates();
        int               phase_left;
        bit               narrow_slots;
        bit               tiny_values;
        int               base_slot;
        int               roll;
        int               live_slots [$];
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        phase_left   = 0;
        narrow_slots = 1'b0;
        tiny_values  = 1'b0;
        base_slot    = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left   = $urandom_range(40, 160);
                narrow_slots = $urandom_range(0, 1);
                tiny_values  = ($urandom_range(0, 2) == 0);
                base_slot    = $urandom_range(0, SLOTS - 16);
            end
            phase_left--;
            live_slots.delete();
            for (int s = 0; s < SLOTS; s++) begin
                if (sb.slot_live[s]) live_slots.push_back(s);
            end
            pos  = narrow_slots ? POS_W'(base_slot + $urandom_range(0, 15)) : POS_W'($urandom);
            val  = tiny_values ? VAL_W'($urandom_range(1, 6)) : VAL_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                // zero load, rejected
                send_update(ACT_LOAD, pos, '0);
            end else if (roll < 9) begin
                // remove of any slot, often a dead one
                send_update(ACT_REMOVE, pos, VAL_W'($urandom));
            end else if (roll < ((live_slots.size() > 48) ? 60 : 35) &&
                         live_slots.size() > 0) begin
                pos = POS_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
                send_update(ACT_REMOVE, pos, VAL_W'($urandom));
            end else begin
                if (val == '0) val = VAL_W'(1);
                send_update(ACT_LOAD, pos, val);
            end
        end
    endtask

    // Main sequence
    initial begin
        sb = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_action   = ACT_LOAD;
        i_position = '0;
        i_value    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tree, zero loads, extremes, ties, reloads, dead removes
        send_update(ACT_REMOVE, 10'd5, '1);
        send_update(ACT_LOAD, 10'd3, '0);
        send_update(ACT_LOAD, 10'd0, 31'h7FFF_FFFF);
        send_update(ACT_LOAD, 10'd1023, 31'd1);
        send_update(ACT_LOAD, 10'd512, 31'h7FFF_FFFF);
        send_update(ACT_LOAD, 10'd700, 31'd1);
        send_update(ACT_LOAD, 10'd0, '0);
        send_update(ACT_LOAD, 10'd0, 31'h2AAA_AAAA);
        send_update(ACT_LOAD, 10'd1023, 31'h5555_5555);
        send_update(ACT_REMOVE, 10'd0, '0);
        send_update(ACT_REMOVE, 10'd0, '0);
        send_update(ACT_REMOVE, 10'd512, '0);
        send_update(ACT_REMOVE, 10'd700, '0);
        send_update(ACT_REMOVE, 10'd1023, '0);
        send_update(ACT_LOAD, 10'h155, 31'h4000_0000);
        send_update(ACT_LOAD, 10'h2AA, 31'h3FFF_FFFF);
        send_update(ACT_LOAD, 10'h155, 31'h3FFF_FFFF);
        send_update(ACT_REMOVE, 10'h155, '0);
        send_update(ACT_REMOVE, 10'h2AA, '0);
        send_update(ACT_REMOVE, 10'd1023, '0);

        run_random_updates();

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain remaining results, then a short quiet period
        while (sb.pending_extremes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/lmm_pkg.sv
sv/lmm_node_ram.sv
sv/lmm_merge.sv
sv/live_min_max_tree_unit.sv
sim/live_min_max_tree_unit_tb.sv
